>>> rtl/core/cirgb_pkg.sv
package cirgb_pkg;

  localparam int BV_W              = 13;
  localparam int OUT_W             = 13;
  localparam int OUT_FRAC_BITS_DEF = 12;
  localparam int N_CH              = 3;
  localparam int CH_W              = 2;

  // Index held as v = 5 * code, i.e. colour index times 5120.
  localparam int V_W   = 15;
  localparam int E_W   = 13;
  localparam int SQ_W  = 2 * E_W;
  localparam int B_W   = 20;
  localparam int C_W   = 12;
  localparam int N_W   = 37;
  localparam int A_W   = 29;
  localparam int M_W   = 12;
  localparam int R_W   = 28;
  localparam int RECIP_SH = 32;
  localparam int Q_W   = A_W + R_W - RECIP_SH;

  typedef logic signed [V_W-1:0]  v_t;
  typedef logic        [E_W-1:0]  e_t;
  typedef logic        [SQ_W-1:0] sq_t;
  typedef logic signed [N_W-1:0]  num_t;
  typedef logic        [A_W-1:0]  quo_in_t;
  typedef logic        [Q_W-1:0]  quo_t;
  typedef logic        [OUT_W-1:0] chan_t;

  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

  localparam chan_t OUT_MAX = '1;

  // Segment boundaries in v units
  localparam v_t V_LO      = -15'sd2048;  // -0.4
  localparam v_t V_ZERO    = 15'sd0;
  localparam v_t V_0_4     = 15'sd2048;
  localparam v_t V_1_5     = 15'sd7680;
  localparam v_t V_1_6     = 15'sd8192;
  localparam v_t V_1_94    = 15'sd9933;   // first step at or above 1.94
  localparam v_t V_HI      = 15'sd10240;  // 2.0

  // SEG_ONE is the flat 1.0 segment, SEG_ZERO lies outside every segment
  typedef enum logic [3:0] {
    SEG_ZERO,
    SEG_ONE,
    SEG_R0,
    SEG_R1,
    SEG_G0,
    SEG_G1,
    SEG_G2,
    SEG_G3,
    SEG_B1,
    SEG_B2
  } seg_t;

  function automatic seg_t seg_pick(logic [CH_W-1:0] ch, v_t v);
    seg_t s;
    s = SEG_ZERO;
    unique case (ch)
      CH_RED: begin
        if (v < V_ZERO) s = SEG_R0;
        else if (v < V_0_4) s = SEG_R1;
        else s = SEG_ONE;
      end
      CH_GREEN: begin
        if (v < V_ZERO) s = SEG_G0;
        else if (v < V_0_4) s = SEG_G1;
        else if (v < V_1_6) s = SEG_G2;
        else if (v < V_HI) s = SEG_G3;
        else s = SEG_ZERO;
      end
      CH_BLUE: begin
        if (v < V_0_4) s = SEG_ONE;
        else if (v < V_1_5) s = SEG_B1;
        else if (v < V_1_94) s = SEG_B2;
        else s = SEG_ZERO;
      end
      default: s = SEG_ZERO;
    endcase
    return s;
  endfunction

  // Offset of v into its segment; flat segments need none
  function automatic e_t seg_e(seg_t s, v_t v);
    logic signed [V_W:0] d;
    d = '0;
    unique case (s)
      SEG_R0, SEG_G0: d = (V_W+1)'(v) - (V_W+1)'(V_LO);
      SEG_R1, SEG_G1: d = (V_W+1)'(v);
      SEG_G2, SEG_B1: d = (V_W+1)'(v) - (V_W+1)'(V_0_4);
      SEG_G3:         d = (V_W+1)'(v) - (V_W+1)'(V_1_6);
      SEG_B2:         d = (V_W+1)'(v) - (V_W+1)'(V_1_5);
      default:        d = '0;
    endcase
    return d[E_W-1:0];
  endfunction

  // Numerator N = a + b*e + c*e*e over denominator m * 2^p
  function automatic num_t seg_a(seg_t s);
    num_t a;
    unique case (s)
      SEG_ONE: a = 37'sd419430400;
      SEG_R0:  a = 37'sd255852544;
      SEG_R1:  a = 37'sd348127232;
      SEG_G0:  a = 37'sd293601280;
      SEG_G1:  a = 37'sd364904448;
      SEG_G2:  a = 37'sd3699376128;
      SEG_G3:  a = 37'sd343932928;
      SEG_B1:  a = 37'sd3171942400;
      SEG_B2:  a = 37'sd7993294848;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [B_W-1:0] seg_b(seg_t s);
    logic signed [B_W-1:0] b;
    unique case (s)
      SEG_R0:  b = 20'sd22528;
      SEG_R1:  b = 20'sd34816;
      SEG_G0:  b = 20'sd14336;
      SEG_G1:  b = 20'sd22528;
      SEG_G2:  b = -20'sd98304;
      SEG_B1:  b = -20'sd264704;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic signed [C_W-1:0] seg_c(seg_t s);
    logic signed [C_W-1:0] c;
    unique case (s)
      SEG_R0, SEG_G0, SEG_B1: c = 12'sd10;
      SEG_G3:                 c = -12'sd50;
      SEG_B2:                 c = -12'sd1500;
      default:                c = '0;
    endcase
    return c;
  endfunction

  function automatic int seg_p(seg_t s);
    int p;
    unique case (s)
      SEG_B1:  p = 20;
      SEG_B2:  p = 22;
      default: p = 24;
    endcase
    return p;
  endfunction

  function automatic logic [M_W-1:0] seg_m(seg_t s);
    logic [M_W-1:0] m;
    unique case (s)
      SEG_G2:         m = 12'd225;
      SEG_B1, SEG_B2: m = 12'd3025;
      default:        m = 12'd25;
    endcase
    return m;
  endfunction

  // floor(2^32 / m)
  function automatic logic [R_W-1:0] seg_recip(seg_t s);
    logic [R_W-1:0] r;
    unique case (s)
      SEG_G2:         r = 28'd19088743;
      SEG_B1, SEG_B2: r = 28'd1419823;
      default:        r = 28'd171798691;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/color_index_to_rgb_unit.sv
// B-V colour index to RGB intensity converter.
// Input channel: in_valid / in_ready carry one signed B-V index per beat
// (10 fraction bits). The index is clamped to -0.4 .. 2.0 and each colour
// channel is taken from its own linear or quadratic segment.
// Output channel: out_valid / out_ready carry red, green and blue per beat,
// unsigned with OUT_FRAC_BITS fraction bits, rounded half up, saturated at
// the 13-bit maximum.
// Throughput: one beat per cycle unless a stall fills every stage; the
// eight register stages each hold one item, and the longest step is the
// 29 x 28 bit reciprocal multiply that replaces the division by the
// segment denominator.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and in_ready stays high while
// an empty stage remains, even when the receiver holds out_ready low.
// A stalled output beat keeps its data until taken.
// Reset (rst_n low, synchronous) empties every stage; no payload is lost
// or repeated across a stall.
module color_index_to_rgb_unit #(
  parameter int OUT_FRAC_BITS = cirgb_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [cirgb_pkg::BV_W-1:0]  in_bv_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [cirgb_pkg::OUT_W-1:0] out_red,
  output logic        [cirgb_pkg::OUT_W-1:0] out_green,
  output logic        [cirgb_pkg::OUT_W-1:0] out_blue
);

  import cirgb_pkg::*;

  localparam int NS = 8;
  localparam int MW = Q_W + M_W + 1;

  logic [NS:1] vld_r;
  logic [NS:1] adv;

  v_t                    s1_v_r, s1_v_nxt;
  seg_t                  s2_seg_r [N_CH];
  e_t                    s2_e_r   [N_CH];
  seg_t                  s3_seg_r [N_CH];
  e_t                    s3_e_r   [N_CH];
  sq_t                   s3_sq_r  [N_CH];
  seg_t                  s4_seg_r [N_CH];
  num_t                  s4_p1_r  [N_CH];
  num_t                  s4_p2_r  [N_CH];
  seg_t                  s5_seg_r [N_CH];
  num_t                  s5_n_r   [N_CH];
  num_t                  s5_n_nxt [N_CH];
  seg_t                  s6_seg_r [N_CH];
  logic [N_CH-1:0]       s6_neg_r;
  quo_in_t               s6_a_r   [N_CH];
  seg_t                  s7_seg_r [N_CH];
  logic [N_CH-1:0]       s7_neg_r;
  quo_in_t               s7_a_r   [N_CH];
  quo_t                  s7_q_r   [N_CH];
  quo_t                  s7_q_nxt [N_CH];
  chan_t                 out_r    [N_CH];
  chan_t                 out_nxt  [N_CH];

  // Handshake: a stage loads when empty or when its successor moves
  always_comb begin
    adv[NS] = !vld_r[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld_r[NS];
  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 1: scale by five and clamp
  always_comb begin
    logic signed [V_W:0] xs;
    logic signed [V_W:0] x5;
    xs = (V_W+1)'(in_bv_index);
    x5 = (xs <<< 2) + xs;
    if (x5 < (V_W+1)'(V_LO)) s1_v_nxt = V_LO;
    else if (x5 > (V_W+1)'(V_HI)) s1_v_nxt = V_HI;
    else s1_v_nxt = x5[V_W-1:0];
  end

  // Stage 5 sum with rounding bias folded in
  always_comb begin
    num_t bias;
    for (int c = 0; c < N_CH; c++) begin
      bias = N_W'(seg_m(s4_seg_r[c]));
      bias = bias <<< (seg_p(s4_seg_r[c]) - 1 - OUT_FRAC_BITS);
      s5_n_nxt[c] = seg_a(s4_seg_r[c]) + s4_p1_r[c] + s4_p2_r[c] + bias;
    end
  end

  // Stage 7: quotient estimate, at most one short
  always_comb begin
    logic [A_W+R_W-1:0] prod;
    for (int c = 0; c < N_CH; c++) begin
      prod        = (A_W+R_W)'(s6_a_r[c]) * (A_W+R_W)'(seg_recip(s6_seg_r[c]));
      s7_q_nxt[c] = prod[RECIP_SH +: Q_W];
    end
  end

  // Stage 8: correct the estimate, then saturate
  always_comb begin
    logic [MW-1:0]  qm;
    logic [MW-1:0]  m;
    logic [Q_W:0]   q;
    for (int c = 0; c < N_CH; c++) begin
      m  = MW'(seg_m(s7_seg_r[c]));
      qm = MW'(s7_q_r[c]) * m;
      q  = (Q_W+1)'(s7_q_r[c]);
      if (MW'(s7_a_r[c]) >= qm + m) q = q + 1'b1;
      if (s7_neg_r[c]) out_nxt[c] = '0;
      else if (q > (Q_W+1)'(OUT_MAX)) out_nxt[c] = OUT_MAX;
      else out_nxt[c] = q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [B_W+E_W:0]  p1;
    logic signed [C_W+SQ_W:0] p2;
    if (adv[1]) s1_v_r <= s1_v_nxt;
    for (int c = 0; c < N_CH; c++) begin
      p1 = seg_b(s3_seg_r[c]) * $signed({1'b0, s3_e_r[c]});
      p2 = seg_c(s3_seg_r[c]) * $signed({1'b0, s3_sq_r[c]});
      if (adv[2]) begin
        s2_seg_r[c] <= seg_pick(CH_W'(c), s1_v_r);
        s2_e_r[c]   <= seg_e(seg_pick(CH_W'(c), s1_v_r), s1_v_r);
      end
      if (adv[3]) begin
        s3_seg_r[c] <= s2_seg_r[c];
        s3_e_r[c]   <= s2_e_r[c];
        s3_sq_r[c]  <= s2_e_r[c] * s2_e_r[c];
      end
      if (adv[4]) begin
        s4_seg_r[c] <= s3_seg_r[c];
        s4_p1_r[c]  <= N_W'(p1);
        s4_p2_r[c]  <= N_W'(p2);
      end
      if (adv[5]) begin
        s5_seg_r[c] <= s4_seg_r[c];
        s5_n_r[c]   <= s5_n_nxt[c];
      end
      if (adv[6]) begin
        s6_seg_r[c] <= s5_seg_r[c];
        s6_neg_r[c] <= s5_n_r[c][N_W-1];
        s6_a_r[c]   <= A_W'(s5_n_r[c] >>> (seg_p(s5_seg_r[c]) - OUT_FRAC_BITS));
      end
      if (adv[7]) begin
        s7_seg_r[c] <= s6_seg_r[c];
        s7_neg_r[c] <= s6_neg_r[c];
        s7_a_r[c]   <= s6_a_r[c];
        s7_q_r[c]   <= s7_q_nxt[c];
      end
      if (adv[8]) begin
        out_r[c] <= out_nxt[c];
      end
    end
  end

endmodule

>>> bench/tb_color_index_to_rgb_unit.sv
`timescale 1ns / 100ps

module tb_color_index_to_rgb_unit;
  import cirgb_pkg::*;

  localparam int N_PROBES = 22;
  localparam int N_RANDOM = 1950;
  localparam int FRAC     = OUT_FRAC_BITS_DEF;
  localparam int DRAIN_LIMIT = 4000;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  typedef struct packed {
    logic signed [BV_W-1:0] code;
    bit                     typed;
    rgb_t                   rgb;
  } probe_row_t;

  // lo/hi in units of index * 51200, coefficients in hundredths
  typedef struct {
    longint lo;
    longint hi;
    longint c0;
    longint c1;
    longint c2;
  } span_t;

  localparam int EDGE_CODES [10] = '{-410, -409, 0, 409, 410, 1536, 1638, 1639, 1987, 2048};

  // typed rows: clamped ends, zero, and the top where green and blue drop out
  probe_row_t probe_rows [N_PROBES] = '{
    '{13'sh1000,  1'b1, '{13'd2499, 13'd2867, 13'd4096}},
    '{-13'sd410,  1'b1, '{13'd2499, 13'd2867, 13'd4096}},
    '{-13'sd409,  1'b0, '0},
    '{-13'sd408,  1'b0, '0},
    '{-13'sd1,    1'b0, '0},
    '{13'sd0,     1'b1, '{13'd3400, 13'd3564, 13'd4096}},
    '{13'sd1,     1'b0, '0},
    '{13'sd409,   1'b0, '0},
    '{13'sd410,   1'b0, '0},
    '{13'sd1024,  1'b0, '0},
    '{13'sd1535,  1'b0, '0},
    '{13'sd1536,  1'b0, '0},
    '{13'sd1637,  1'b0, '0},
    '{13'sd1638,  1'b0, '0},
    '{13'sd1639,  1'b0, '0},
    '{13'sd1986,  1'b0, '0},
    '{13'sd1987,  1'b0, '0},
    '{13'sd2047,  1'b0, '0},
    '{13'sd2048,  1'b1, '{13'd4096, 13'd0, 13'd0}},
    '{13'sd2049,  1'b1, '{13'd4096, 13'd0, 13'd0}},
    '{13'sd4095,  1'b1, '{13'd4096, 13'd0, 13'd0}},
    '{-13'sd2731, 1'b0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [BV_W-1:0] in_bv_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  chan_t                  out_red;
  chan_t                  out_green;
  chan_t                  out_blue;

  // payload side-band: typed expectation travels with the beat
  bit   row_typed = 1'b0;
  rgb_t row_rgb = '0;

  rgb_t rgb_due [$];
  bit   no_idle = 1'b0;
  int   mismatches = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_low = 0;
  int   n_high = 0;

  color_index_to_rgb_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_bv_index (in_bv_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

  always #2 clk = ~clk;

  function automatic span_t curve_span(logic [CH_W-1:0] ch, int k);
    span_t s;
    s = '{0, 0, 0, 0, 0};
    case (ch)
      CH_RED: begin
        case (k)
          0: s = '{-20480, 0, 61, 11, 10};
          1: s = '{0, 20480, 83, 17, 0};
          2: s = '{20480, 107520, 100, 0, 0};
          default: ;
        endcase
      end
      CH_GREEN: begin
        case (k)
          0: s = '{-20480, 0, 70, 7, 10};
          1: s = '{0, 20480, 87, 11, 0};
          2: s = '{20480, 81920, 98, -16, 0};
          3: s = '{81920, 102400, 82, 0, -50};
          default: ;
        endcase
      end
      CH_BLUE: begin
        case (k)
          0: s = '{-20480, 20480, 100, 0, 0};
          1: s = '{20480, 76800, 100, -47, 10};
          2: s = '{76800, 99328, 63, 0, -60};
          default: ;
        endcase
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic chan_t channel_level(logic [CH_W-1:0] ch, longint u);
    span_t  s;
    longint w;
    longint d;
    longint num;
    longint den;
    longint r;
    for (int k = 0; k < 4; k++) begin
      s = curve_span(ch, k);
      if (u >= s.lo && u < s.hi) begin
        w   = s.hi - s.lo;
        d   = u - s.lo;
        num = s.c0 * w * w + s.c1 * d * w + s.c2 * d * d;
        den = 100 * w * w;
        if (num <= 0) return '0;
        r = ((num <<< FRAC) + den / 2) / den;
        if (r > longint'(OUT_MAX)) r = longint'(OUT_MAX);
        return chan_t'(r);
      end
    end
    return '0;
  endfunction

  function automatic rgb_t bv_to_rgb(logic signed [BV_W-1:0] code);
    longint u;
    rgb_t   c;
    u = longint'(code) * 50;
    if (u < -20480) u = -20480;
    if (u > 102400) u = 102400;
    c.red   = channel_level(CH_RED, u);
    c.green = channel_level(CH_GREEN, u);
    c.blue  = channel_level(CH_BLUE, u);
    return c;
  endfunction

  function automatic logic signed [BV_W-1:0] pick_index();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return BV_W'($urandom());
    if (sel < 4) return BV_W'(EDGE_CODES[$urandom_range(0, 9)] + int'($urandom_range(0, 4)) - 2);
    return BV_W'(int'($urandom_range(0, 2458)) - 410);
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic send_index(logic signed [BV_W-1:0] code, bit typed, rgb_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_bv_index <= code;
    row_typed   <= typed;
    row_rgb     <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // hold the input until every pending beat has come back
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (rgb_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  always @(posedge clk) begin : watch
    rgb_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rgb_due.size() == 0) begin
          note_mismatch("unexpected beat, red", out_red, 0);
        end else begin
          want = rgb_due.pop_front();
          if (out_red !== want.red) note_mismatch("red", out_red, want.red);
          if (out_green !== want.green) note_mismatch("green", out_green, want.green);
          if (out_blue !== want.blue) note_mismatch("blue", out_blue, want.blue);
          n_checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (row_typed) rgb_due = {rgb_due, row_rgb};
        else rgb_due = {rgb_due, bv_to_rgb(in_bv_index)};
        if (in_bv_index <= -410) n_low++;
        if (in_bv_index > 2048) n_high++;
      end
    end
  end

  initial begin : sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_PROBES; i++) begin
      send_index(probe_rows[i].code, probe_rows[i].typed, probe_rows[i].rgb);
    end
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      // some blocks run with no idling on either side
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == N_RANDOM / 2) drain_results();
      send_index(pick_index(), 1'b0, '0);
    end
    no_idle = 1'b0;

    drain_results();
    repeat (16) @(posedge clk);
    if (rgb_due.size() != 0) note_mismatch("beats never returned", rgb_due.size(), 0);

    $display("Sent %0d colour indices (%0d clamped below -0.4, %0d above 2.0)",
             n_sent, n_low, n_high);
    $display("Checked %0d RGB beats under random input gaps and output stalls", n_checked);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
